@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Types, codes and sizes shared by the ping-pong sample capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

   // points held by one capture bank
   localparam int BANK_POINTS = 32;

   localparam int ADDR_W     = $clog2(2 * BANK_POINTS);
   localparam int FILL_W     = $clog2(BANK_POINTS + 1);
   localparam int COUNT_W    = 6;
   localparam int STAMP_W    = 32;
   localparam int SAMPLE_W   = 12;
   localparam int INTERVAL_W = 16;
   localparam int KIND_W     = 3;

   typedef enum logic [KIND_W-1:0] {
      REQ_ADC_A = 3'd0,
      REQ_ADC_B = 3'd1,
      REQ_START = 3'd2,
      REQ_FETCH = 3'd3,
      REQ_STOP  = 3'd4
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      RSP_START_ACK = 3'd0,
      RSP_STOP_ACK  = 3'd1,
      RSP_ERROR     = 3'd2,
      RSP_HEADER    = 3'd3,
      RSP_POINT     = 3'd4
   } rsp_kind_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_STREAM = 1'b1
   } state_type;

   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [SAMPLE_W-1:0] chan_a;
      logic [SAMPLE_W-1:0] chan_b;
   } point_type;

   typedef struct packed {
      rsp_kind_type        reply_kind;
      logic                bank;
      logic [COUNT_W-1:0]  point_count;
      point_type           point;
      logic                last;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ src/pps_channel_if.sv @@
// ----------------------------------------------------------------------------
// pps request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_req_if;
   logic                          valid;
   logic                          ready;
   logic [pps_pkg::KIND_W-1:0]    req_type;
   logic [pps_pkg::SAMPLE_W-1:0]  adc_value;

   modport source (output valid, output req_type, output adc_value, input ready);
   modport sink   (input valid, input req_type, input adc_value, output ready);
endinterface

interface pps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pps_pkg::KIND_W-1:0]    reply_kind;
   logic                          bank;
   logic [pps_pkg::COUNT_W-1:0]   point_count;
   logic [pps_pkg::STAMP_W-1:0]   stamp;
   logic [pps_pkg::SAMPLE_W-1:0]  chan_a;
   logic [pps_pkg::SAMPLE_W-1:0]  chan_b;
   logic                          last;

   modport source (output valid, output reply_kind, output bank, output point_count,
                   output stamp, output chan_a, output chan_b, output last,
                   input ready);
   modport sink   (input valid, input reply_kind, input bank, input point_count,
                   input stamp, input chan_a, input chan_b, input last,
                   output ready);
endinterface

`default_nettype wire

@@ src/ping_pong_sample_capture.sv @@
// ----------------------------------------------------------------------------
// ping_pong_sample_capture
// Two-channel sampler storing timestamped points into two banks used in turn.
// ----------------------------------------------------------------------------
// ADC events, start and stop are acted on as they are accepted; a request is
// accepted in idle once the response register is free. A fetch gives a header
// in the cycle after it is accepted, then the bank's points follow one per
// cycle from the point RAM through a read data stage while the response
// channel is ready; no request is taken until the last point is loaded.
// Back-pressure on the response channel holds the stream while it lasts.
`default_nettype none

module ping_pong_sample_capture (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [pps_pkg::INTERVAL_W-1:0] csr_wr_data,
   pps_req_if.sink                             req_ch,
   pps_rsp_if.source                           rsp_ch
);

   pps_pkg::state_type  state_ff, state_in;

   logic [pps_pkg::INTERVAL_W-1:0] interval_ff;
   logic                           running_ff, running_in;
   logic                           bank_ff, bank_in;
   logic [pps_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic [pps_pkg::STAMP_W-1:0]    time_ff, time_in;
   logic [1:0]                     flags_ff, flags_in;
   logic [pps_pkg::SAMPLE_W-1:0]   lat_a_ff, lat_a_in;
   logic [pps_pkg::SAMPLE_W-1:0]   lat_b_ff, lat_b_in;

   // fetch stream control
   logic                           str_bank_ff, str_bank_in;
   logic [pps_pkg::FILL_W-1:0]     str_cnt_ff, str_cnt_in;
   logic [pps_pkg::FILL_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic                           rd_last_ff;
   pps_pkg::point_type             rd_data_ff;

   logic                           out_vld_ff, out_vld_in;
   pps_pkg::rsp_payload_type       out_ff, out_in;

   pps_pkg::point_type             mem [2*pps_pkg::BANK_POINTS];
   logic                           mem_we;
   logic [pps_pkg::ADDR_W-1:0]     mem_waddr;
   pps_pkg::point_type             mem_wdata;
   logic                           rd_en;
   logic [pps_pkg::ADDR_W-1:0]     rd_addr;

   logic                           req_accept;
   logic                           out_free;
   logic                           load_out;

   // ------------------------------------------------------------------------
   // handshake and read control
   // ------------------------------------------------------------------------
   always_comb begin
      out_free     = !out_vld_ff || rsp_ch.ready;
      req_ch.ready = (state_ff == pps_pkg::ST_IDLE) && out_free;
      req_accept   = req_ch.valid && req_ch.ready;
      load_out     = rd_vld_ff && out_free;
      rd_en        = (state_ff == pps_pkg::ST_STREAM) && (rd_ptr_ff < str_cnt_ff)
                     && (!rd_vld_ff || load_out);
      rd_addr      = pps_pkg::ADDR_W'(rd_ptr_ff)
                     + (str_bank_ff ? pps_pkg::ADDR_W'(pps_pkg::BANK_POINTS)
                                    : pps_pkg::ADDR_W'(0));
   end

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (req_accept && req_ch.req_type == pps_pkg::REQ_FETCH && running_ff
                && fill_ff != '0) begin
               state_in = pps_pkg::ST_STREAM;
            end
         end
         pps_pkg::ST_STREAM: begin
            if (load_out && rd_last_ff) begin
               state_in = pps_pkg::ST_IDLE;
            end
         end
         default: state_in = pps_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // request handling and response register
   // ------------------------------------------------------------------------
   always_comb begin
      logic [1:0] flags_new;

      running_in  = running_ff;
      bank_in     = bank_ff;
      fill_in     = fill_ff;
      time_in     = time_ff;
      flags_in    = flags_ff;
      lat_a_in    = lat_a_ff;
      lat_b_in    = lat_b_ff;
      str_bank_in = str_bank_ff;
      str_cnt_in  = str_cnt_ff;
      rd_ptr_in   = rd_ptr_ff;
      mem_we      = 1'b0;
      mem_waddr   = pps_pkg::ADDR_W'(fill_ff)
                    + (bank_ff ? pps_pkg::ADDR_W'(pps_pkg::BANK_POINTS)
                               : pps_pkg::ADDR_W'(0));
      mem_wdata   = '0;
      out_vld_in  = out_vld_ff && !rsp_ch.ready;
      out_in      = out_ff;
      flags_new   = flags_ff;

      if (req_accept) begin
         case (req_ch.req_type)
            pps_pkg::REQ_ADC_A,
            pps_pkg::REQ_ADC_B: begin
               if (req_ch.req_type == pps_pkg::REQ_ADC_A) begin
                  lat_a_in     = req_ch.adc_value;
                  flags_new[0] = 1'b1;
               end else begin
                  lat_b_in     = req_ch.adc_value;
                  flags_new[1] = 1'b1;
               end
               flags_in = flags_new;
               // both channels in while running: store a point
               if (flags_new == 2'b11 && running_ff) begin
                  if (fill_ff >= pps_pkg::FILL_W'(pps_pkg::BANK_POINTS)) begin
                     running_in = 1'b0;
                  end else begin
                     mem_we           = 1'b1;
                     mem_wdata.stamp  = time_ff;
                     mem_wdata.chan_a = lat_a_in;
                     mem_wdata.chan_b = lat_b_in;
                     time_in  = time_ff + pps_pkg::STAMP_W'(interval_ff);
                     flags_in = 2'b00;
                     fill_in  = fill_ff + pps_pkg::FILL_W'(1);
                     if (fill_in >= pps_pkg::FILL_W'(pps_pkg::BANK_POINTS)) begin
                        running_in = 1'b0;
                     end
                  end
               end
            end
            pps_pkg::REQ_START: begin
               fill_in    = '0;
               bank_in    = 1'b0;
               time_in    = '0;
               running_in = 1'b1;
               out_vld_in = 1'b1;
               out_in     = '0;
               out_in.reply_kind = pps_pkg::RSP_START_ACK;
               out_in.last       = 1'b1;
            end
            pps_pkg::REQ_FETCH: begin
               out_vld_in = 1'b1;
               out_in     = '0;
               out_in.last = 1'b1;
               if (!running_ff) begin
                  out_in.reply_kind = pps_pkg::RSP_ERROR;
               end else begin
                  out_in.reply_kind  = pps_pkg::RSP_HEADER;
                  out_in.bank        = bank_ff;
                  out_in.point_count = pps_pkg::COUNT_W'(fill_ff);
                  if (fill_ff != '0) begin
                     out_in.last = 1'b0;
                     // hand the filled bank to the stream, switch to the other
                     str_bank_in = bank_ff;
                     str_cnt_in  = fill_ff;
                     rd_ptr_in   = '0;
                     bank_in     = !bank_ff;
                     fill_in     = '0;
                  end
               end
            end
            pps_pkg::REQ_STOP: begin
               running_in = 1'b0;
               out_vld_in = 1'b1;
               out_in     = '0;
               out_in.reply_kind = pps_pkg::RSP_STOP_ACK;
               out_in.last       = 1'b1;
            end
            default: begin
               // unused codes: drop
            end
         endcase
      end

      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + pps_pkg::FILL_W'(1);
      end

      if (load_out) begin
         out_vld_in        = 1'b1;
         out_in.reply_kind = pps_pkg::RSP_POINT;
         out_in.bank       = str_bank_ff;
         out_in.point_count = '0;
         out_in.point      = rd_data_ff;
         out_in.last       = rd_last_ff;
      end

      rd_vld_in = rd_en || (rd_vld_ff && !load_out);
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pps_pkg::ST_IDLE;
         interval_ff <= pps_pkg::INTERVAL_W'(1);
         running_ff  <= 1'b0;
         bank_ff     <= 1'b0;
         fill_ff     <= '0;
         time_ff     <= '0;
         flags_ff    <= 2'b00;
         lat_a_ff    <= '0;
         lat_b_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
         running_ff  <= running_in;
         bank_ff     <= bank_in;
         fill_ff     <= fill_in;
         time_ff     <= time_in;
         flags_ff    <= flags_in;
         lat_a_ff    <= lat_a_in;
         lat_b_ff    <= lat_b_in;
         rd_vld_ff   <= rd_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      str_bank_ff <= str_bank_in;
      str_cnt_ff  <= str_cnt_in;
      rd_ptr_ff   <= rd_ptr_in;
      out_ff      <= out_in;
      if (rd_en) begin
         rd_last_ff <= (rd_ptr_ff == str_cnt_ff - pps_pkg::FILL_W'(1));
      end
   end

   // point RAM; stores happen only in idle, reads only while streaming
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.reply_kind  = out_ff.reply_kind;
   assign rsp_ch.bank        = out_ff.bank;
   assign rsp_ch.point_count = out_ff.point_count;
   assign rsp_ch.stamp       = out_ff.point.stamp;
   assign rsp_ch.chan_a      = out_ff.point.chan_a;
   assign rsp_ch.chan_b      = out_ff.point.chan_b;
   assign rsp_ch.last        = out_ff.last;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= pps_pkg::FILL_W'(pps_pkg::BANK_POINTS))
      else $error("fill index beyond bank size");

   a_no_store_in_stream: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == pps_pkg::ST_IDLE)
      else $error("point stored while a bank is streaming");

   a_read_stage_in_stream: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == pps_pkg::ST_STREAM)
      else $error("read data pending outside a stream");

   a_stream_ends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pps_pkg::ST_STREAM && state_in == pps_pkg::ST_IDLE)
      |=> out_vld_ff && out_ff.last && out_ff.reply_kind == pps_pkg::RSP_POINT)
      else $error("stream finished without a last point");

endmodule

`default_nettype wire

@@ test/pps_capture_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_capture_scoreboard
// Watches the request, response and register ports of the ping-pong sample
// capture block, keeps its own copy of the capture state, works out the
// replies each accepted request should give and compares them in order.
// ----------------------------------------------------------------------------

module pps_capture_scoreboard
   import pps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [INTERVAL_W-1:0] csr_wr_data,
   pps_req_if                         req_ch,
   pps_rsp_if                         rsp_ch,
   output int                         fail_count,
   output int                         replies_owed
);

   // cap the printed lines, keep counting
   localparam int PRINT_CAP = 200;

   logic [INTERVAL_W-1:0] step_ms;
   logic                  capturing;
   logic                  fill_bank;
   int unsigned           fill_count;
   logic [STAMP_W-1:0]    clock_ms;
   logic [1:0]            chan_ready;
   logic [SAMPLE_W-1:0]   held_a;
   logic [SAMPLE_W-1:0]   held_b;
   point_type             point_log [2*BANK_POINTS];
   rsp_payload_type       pending_replies [$];

   task automatic flag_mismatch(string text);
      if (fail_count < PRINT_CAP)
         $display("%0t ns: %s", $time, text);
      fail_count++;
   endtask

   function automatic rsp_payload_type make_reply(rsp_kind_type kind, logic bank,
                                                  logic [COUNT_W-1:0] count,
                                                  point_type pt, logic last);
      rsp_payload_type r;
      r.reply_kind  = kind;
      r.bank        = bank;
      r.point_count = count;
      r.point       = pt;
      r.last        = last;
      return r;
   endfunction

   task automatic store_if_ready();
      if (chan_ready != 2'b11 || !capturing)
         return;
      if (fill_count >= BANK_POINTS) begin
         capturing = 1'b0;
         return;
      end
      point_log[int'(fill_bank) * BANK_POINTS + fill_count] =
         '{stamp: clock_ms, chan_a: held_a, chan_b: held_b};
      clock_ms   = clock_ms + {{(STAMP_W-INTERVAL_W){1'b0}}, step_ms};
      chan_ready = 2'b00;
      fill_count++;
      // the final slot is used, then capture halts
      if (fill_count >= BANK_POINTS)
         capturing = 1'b0;
   endtask

   task automatic take_request(logic [KIND_W-1:0] code, logic [SAMPLE_W-1:0] value);
      int unsigned n;
      logic        bank;
      case (code)
         REQ_ADC_A: begin
            held_a        = value;
            chan_ready[0] = 1'b1;
            store_if_ready();
         end
         REQ_ADC_B: begin
            held_b        = value;
            chan_ready[1] = 1'b1;
            store_if_ready();
         end
         REQ_START: begin
            // flags and held samples survive a start
            fill_count = 0;
            fill_bank  = 1'b0;
            clock_ms   = '0;
            capturing  = 1'b1;
            pending_replies.push_back(make_reply(RSP_START_ACK, 1'b0, '0, '0, 1'b1));
         end
         REQ_FETCH: begin
            if (!capturing) begin
               pending_replies.push_back(make_reply(RSP_ERROR, 1'b0, '0, '0, 1'b1));
            end else begin
               n    = fill_count;
               bank = fill_bank;
               pending_replies.push_back(make_reply(RSP_HEADER, bank, COUNT_W'(n), '0,
                                                    n == 0));
               for (int i = 0; i < n; i++)
                  pending_replies.push_back(make_reply(RSP_POINT, bank, '0,
                     point_log[int'(bank) * BANK_POINTS + i], i + 1 == n));
               // an empty bank stays active
               if (n != 0) begin
                  fill_bank  = ~bank;
                  fill_count = 0;
               end
            end
         end
         REQ_STOP: begin
            capturing = 1'b0;
            pending_replies.push_back(make_reply(RSP_STOP_ACK, 1'b0, '0, '0, 1'b1));
         end
         default: ;
      endcase
   endtask

   task automatic check_reply();
      rsp_payload_type want;
      if (pending_replies.size() == 0) begin
         flag_mismatch($sformatf("reply of kind %0d with none outstanding",
                                 rsp_ch.reply_kind));
         return;
      end
      want = pending_replies.pop_front();
      if (rsp_ch.reply_kind !== want.reply_kind)
         flag_mismatch($sformatf("reply_kind: expected %0d got %0d",
                                 want.reply_kind, rsp_ch.reply_kind));
      if (rsp_ch.bank !== want.bank)
         flag_mismatch($sformatf("bank: expected %0d got %0d", want.bank, rsp_ch.bank));
      if (rsp_ch.point_count !== want.point_count)
         flag_mismatch($sformatf("point_count: expected %0d got %0d",
                                 want.point_count, rsp_ch.point_count));
      if (rsp_ch.stamp !== want.point.stamp)
         flag_mismatch($sformatf("stamp: expected %0d got %0d",
                                 want.point.stamp, rsp_ch.stamp));
      if (rsp_ch.chan_a !== want.point.chan_a)
         flag_mismatch($sformatf("chan_a: expected %0d got %0d",
                                 want.point.chan_a, rsp_ch.chan_a));
      if (rsp_ch.chan_b !== want.point.chan_b)
         flag_mismatch($sformatf("chan_b: expected %0d got %0d",
                                 want.point.chan_b, rsp_ch.chan_b));
      if (rsp_ch.last !== want.last)
         flag_mismatch($sformatf("last: expected %0d got %0d", want.last, rsp_ch.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_ms    = INTERVAL_W'(1);
         capturing  = 1'b0;
         fill_bank  = 1'b0;
         fill_count = 0;
         clock_ms   = '0;
         chan_ready = 2'b00;
         held_a     = '0;
         held_b     = '0;
         fail_count = 0;
         pending_replies.delete();
      end else begin
         if (csr_wr_en)
            step_ms = csr_wr_data;
         // take the request first so a same-edge reply still finds its entry
         if (req_ch.valid && req_ch.ready)
            take_request(req_ch.req_type, req_ch.adc_value);
         if (rsp_ch.valid && rsp_ch.ready)
            check_reply();
      end
      replies_owed <= pending_replies.size();
   end

endmodule

@@ test/ping_pong_sample_capture_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_pong_sample_capture_test
// Drives ADC events and capture commands into the sample capture block under
// changing idle patterns and sample intervals; the scoreboard checks every
// reply and this module gives the verdict.
// ----------------------------------------------------------------------------

module ping_pong_sample_capture_test;
   import pps_pkg::*;

   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = BANK_POINTS + 8;
   localparam int PHASE_ITEMS   = 75;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [INTERVAL_W-1:0] csr_wr_data;

   int          send_idle_pct = 10;
   int          recv_idle_pct = 70;
   bit          hold_go;
   int unsigned items_sent;
   int          stall_cycles;
   int          mismatches;
   int          replies_owed;

   pps_req_if req_ch ();
   pps_rsp_if rsp_ch ();

   ping_pong_sample_capture u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   pps_capture_scoreboard u_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .fail_count   (mismatches),
      .replies_owed (replies_owed)
   );

   always #1 clock = ~clock;

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      int unsigned hold_left;
      bit          hold_taken;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_request(logic [KIND_W-1:0] code, logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= code;
      req_ch.adc_value <= value;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (code <= REQ_STOP)
         items_sent++;
   endtask

   // drop valid, drain every reply, then let a trailing fetch finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (replies_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(logic [INTERVAL_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(4095));
      endcase
   endfunction

   task automatic send_point_pair();
      // now and then a stray event throws the pairing off
      if ($urandom_range(7) == 0)
         send_request($urandom_range(1) ? REQ_ADC_B : REQ_ADC_A, pick_sample());
      if ($urandom_range(1)) begin
         send_request(REQ_ADC_A, pick_sample());
         send_request(REQ_ADC_B, pick_sample());
      end else begin
         send_request(REQ_ADC_B, pick_sample());
         send_request(REQ_ADC_A, pick_sample());
      end
   endtask

   task automatic capture_burst();
      int pairs;
      if ($urandom_range(1))
         send_request(REQ_START, pick_sample());
      // mostly short runs, sometimes enough to fill a bank
      pairs = ($urandom_range(6) == 0) ? $urandom_range(BANK_POINTS - 2, BANK_POINTS + 2)
                                       : $urandom_range(5);
      for (int i = 0; i < pairs; i++)
         send_point_pair();
      case ($urandom_range(11))
         0:       send_request(REQ_STOP, pick_sample());
         1:       send_request(KIND_W'($urandom_range(7, 5)), pick_sample());
         2:       send_request(REQ_FETCH, pick_sample());
         default: ;
      endcase
      send_request(REQ_FETCH, pick_sample());
   endtask

   task automatic random_phase(int unsigned count);
      int unsigned target;
      target = items_sent + count;
      while (items_sent < target)
         capture_burst();
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= REQ_ADC_A;
      req_ch.adc_value <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_interval('1);

      // directed: commands while stopped, kept flags, empty bank, unused codes
      send_request(REQ_FETCH, 12'd0);
      send_request(REQ_STOP, 12'd0);
      send_request(REQ_ADC_A, 12'hFFF);
      send_request(REQ_ADC_B, 12'h000);
      send_request(REQ_START, 12'hFFF);
      send_request(REQ_ADC_A, 12'h000);
      send_request(REQ_ADC_B, 12'hFFF);
      send_request(REQ_ADC_A, 12'hFFF);
      send_request(REQ_FETCH, 12'h000);
      send_request(REQ_FETCH, 12'hFFF);
      send_request(3'd5, 12'hFFF);
      send_request(3'd6, 12'h000);
      send_request(3'd7, 12'hFFF);
      send_request(REQ_ADC_B, 12'hAAA);
      send_request(REQ_ADC_A, 12'h555);
      send_request(REQ_FETCH, 12'h000);
      send_request(REQ_STOP, 12'h000);
      send_request(REQ_ADC_A, 12'd100);
      send_request(REQ_ADC_B, 12'd200);
      send_request(REQ_FETCH, 12'h000);
      send_request(REQ_STOP, 12'h000);
      send_request(REQ_START, 12'h000);
      send_request(REQ_ADC_A, 12'd7);
      send_request(REQ_FETCH, 12'h000);

      settle();
      write_interval('0);
      random_phase(PHASE_ITEMS);

      settle();
      send_idle_pct <= 70;
      recv_idle_pct <= 10;
      write_interval(16'd1);
      random_phase(PHASE_ITEMS);

      settle();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_interval(INTERVAL_W'($urandom_range(65534, 2)));
      // hold the response side while requests keep coming
      hold_go <= 1'b1;
      send_request(REQ_START, pick_sample());
      for (int i = 0; i < 3; i++)
         send_point_pair();
      send_request(REQ_FETCH, pick_sample());
      send_request(REQ_STOP, pick_sample());
      send_request(REQ_FETCH, pick_sample());
      random_phase(PHASE_ITEMS);

      settle();
      if (mismatches == 0 && replies_owed == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
